/* design/dms_pkg.sv */
// ----------------------------------------------------------------------------
// dms_pkg
// Shared types and constants for the deadline-monotonic selector.
// ----------------------------------------------------------------------------
package dms_pkg;

  // Entry kinds carried on the input tuser bit.
  localparam logic KIND_RUN     = 1'b0;
  localparam logic KIND_RELEASE = 1'b1;

  // Fixed result field widths.
  localparam int OUT_ID_W    = 16;
  localparam int SLICE_W     = 32;
  localparam int OUT_DATA_W  = 48;
  localparam int OUT_USER_W  = 3;

  // Result tuser bit positions.
  localparam int USR_VALID  = 0;
  localparam int USR_MISSED = 1;
  localparam int USR_ORDER  = 2;

  // Status of a finished scheduling call.
  typedef struct packed {
    logic miss_found;
    logic best_found;
    logic rmin_found;
    logic order_err;
  } call_flags_t;

endpackage

/* design/dms_acc.sv */
// ----------------------------------------------------------------------------
// dms_acc
// Per-call accumulator: folds one queue entry per ent_go cycle into the running
// miss, best-thread and nearest-release records, and presents the updated
// records so the caller can capture them on the last entry of a call.
// ----------------------------------------------------------------------------
module dms_acc #(
  parameter int TIME_WIDTH = 31,
  parameter int ID_WIDTH   = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       ent_go,
  input  logic                       ent_kind,
  input  logic [ID_WIDTH-1:0]        ent_id,
  input  logic [TIME_WIDTH-1:0]      ent_rel,
  input  logic [TIME_WIDTH-1:0]      ent_abs,
  input  logic [TIME_WIDTH-1:0]      ent_rem,
  input  logic [TIME_WIDTH-1:0]      ent_rel_at,
  input  logic [TIME_WIDTH-1:0]      ent_now,
  input  logic                       ent_last,
  output dms_pkg::call_flags_t       sum_flags,
  output logic [ID_WIDTH-1:0]        sum_miss_id,
  output logic [ID_WIDTH-1:0]        sum_best_id,
  output logic [TIME_WIDTH-1:0]      sum_best_rem,
  output logic signed [TIME_WIDTH:0] sum_best_stop,
  output logic signed [TIME_WIDTH:0] sum_rmin
);

  localparam int OW = TIME_WIDTH + 1;

  // Call state.
  logic                   in_batch_r, in_batch_nxt;
  logic [TIME_WIDTH-1:0]  batch_time_r, batch_time_nxt;
  logic                   rel_phase_r, rel_phase_nxt;
  dms_pkg::call_flags_t   flags_r, flags_nxt;
  logic [ID_WIDTH-1:0]    miss_id_r, miss_id_nxt;
  logic [ID_WIDTH-1:0]    best_id_r, best_id_nxt;
  logic [TIME_WIDTH-1:0]  best_rel_r, best_rel_nxt;
  logic [TIME_WIDTH-1:0]  best_rem_r, best_rem_nxt;
  logic signed [OW-1:0]   best_stop_r, best_stop_nxt;
  logic signed [OW-1:0]   rmin_r, rmin_nxt;

  logic                   is_run;
  logic                   run_ok;
  logic [TIME_WIDTH-1:0]  bt;
  logic                   beats;
  logic signed [OW-1:0]   off;
  logic signed [OW-1:0]   stop;

  // Entry evaluation against the records so far.
  always_comb begin
    is_run = (ent_kind == dms_pkg::KIND_RUN);
    run_ok = is_run && !rel_phase_r;
    bt     = in_batch_r ? batch_time_r : ent_now;
    beats  = !flags_r.best_found || (ent_rel < best_rel_r) ||
             ((ent_rel == best_rel_r) && (ent_id < best_id_r));
    off    = $signed({1'b0, ent_rel_at}) - $signed({1'b0, bt});
    stop   = $signed({1'b0, ent_abs}) - $signed({1'b0, bt});
  end

  // Record updates for the current entry.
  always_comb begin
    in_batch_nxt   = 1'b1;
    batch_time_nxt = bt;
    rel_phase_nxt  = rel_phase_r | !is_run;
    flags_nxt      = flags_r;
    miss_id_nxt    = miss_id_r;
    best_id_nxt    = best_id_r;
    best_rel_nxt   = best_rel_r;
    best_rem_nxt   = best_rem_r;
    best_stop_nxt  = best_stop_r;
    rmin_nxt       = rmin_r;

    flags_nxt.order_err = flags_r.order_err | (is_run & rel_phase_r);

    if (run_ok && (ent_abs <= bt) && (!flags_r.miss_found || (ent_id < miss_id_r))) begin
      flags_nxt.miss_found = 1'b1;
      miss_id_nxt          = ent_id;
    end

    if (run_ok && beats) begin
      flags_nxt.best_found = 1'b1;
      best_id_nxt          = ent_id;
      best_rel_nxt         = ent_rel;
      best_rem_nxt         = ent_rem;
      best_stop_nxt        = stop;
    end

    if (!is_run && beats && (!flags_r.rmin_found || (off < rmin_r))) begin
      flags_nxt.rmin_found = 1'b1;
      rmin_nxt             = off;
    end
  end

  // Control state clears at the end of every call.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_batch_r  <= 1'b0;
      rel_phase_r <= 1'b0;
      flags_r     <= '0;
    end else if (ent_go) begin
      if (ent_last) begin
        in_batch_r  <= 1'b0;
        rel_phase_r <= 1'b0;
        flags_r     <= '0;
      end else begin
        in_batch_r  <= in_batch_nxt;
        rel_phase_r <= rel_phase_nxt;
        flags_r     <= flags_nxt;
      end
    end
  end

  // Record payloads are only read behind their found flags.
  always_ff @(posedge clk) begin
    if (ent_go) begin
      batch_time_r <= batch_time_nxt;
      miss_id_r    <= miss_id_nxt;
      best_id_r    <= best_id_nxt;
      best_rel_r   <= best_rel_nxt;
      best_rem_r   <= best_rem_nxt;
      best_stop_r  <= best_stop_nxt;
      rmin_r       <= rmin_nxt;
    end
  end

  assign sum_flags     = flags_nxt;
  assign sum_miss_id   = miss_id_nxt;
  assign sum_best_id   = best_id_nxt;
  assign sum_best_rem  = best_rem_nxt;
  assign sum_best_stop = best_stop_nxt;
  assign sum_rmin      = rmin_nxt;

endmodule

/* design/deadline_monotonic_selector_top.sv */
// ----------------------------------------------------------------------------
// deadline_monotonic_selector_top
// Deadline-monotonic thread selector over a streamed run and release queue.
// ----------------------------------------------------------------------------
// The block takes one queue entry per cycle while in_tready is high. A
// scheduling call is the run entries followed by the release entries, closed
// by tlast; the current time comes from the first request of the call. One
// result is produced per call: the call-summary register captures the folded
// call at the accepting edge and feeds the output register once that register
// is free. The only throughput limit is backpressure: in_tready drops only
// while both the summary register and the output register hold results the
// sink has not taken.
module deadline_monotonic_selector_top #(
  parameter int TIME_WIDTH = 31,
  parameter int ID_WIDTH   = 16
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  // thread_id, relative_deadline, absolute_deadline, remaining_work,
  // release_at, now_time, then zero padding.
  input  logic [((ID_WIDTH + 5 * TIME_WIDTH + 7) / 8) * 8 - 1:0] in_tdata,
  // entry_kind
  input  logic in_tuser,
  input  logic in_tlast,
  output logic out_tvalid,
  input  logic out_tready,
  // chosen_id[15:0], slice_ticks[47:16]
  output logic [dms_pkg::OUT_DATA_W-1:0] out_tdata,
  // chosen_valid, deadline_missed, order_error
  output logic [dms_pkg::OUT_USER_W-1:0] out_tuser
);

  localparam int OW    = TIME_WIDTH + 1;
  localparam int EXT_W = (OW > dms_pkg::SLICE_W) ? OW : dms_pkg::SLICE_W;
  localparam int IDX_W = (ID_WIDTH > dms_pkg::OUT_ID_W) ? ID_WIDTH : dms_pkg::OUT_ID_W;

  logic                   in_go;
  logic                   fin_move;
  logic                   out_free;

  dms_pkg::call_flags_t   sum_flags;
  logic [ID_WIDTH-1:0]    sum_miss_id;
  logic [ID_WIDTH-1:0]    sum_best_id;
  logic [TIME_WIDTH-1:0]  sum_best_rem;
  logic signed [OW-1:0]   sum_best_stop;
  logic signed [OW-1:0]   sum_rmin;

  logic                   fin_valid_r;
  dms_pkg::call_flags_t   fin_flags_r;
  logic [ID_WIDTH-1:0]    fin_miss_id_r;
  logic [ID_WIDTH-1:0]    fin_best_id_r;
  logic [TIME_WIDTH-1:0]  fin_best_rem_r;
  logic signed [OW-1:0]   fin_best_stop_r;
  logic signed [OW-1:0]   fin_rmin_r;

  logic                   res_valid;
  logic                   res_missed;
  logic [ID_WIDTH-1:0]    res_id;
  logic signed [OW-1:0]   res_stop;
  logic signed [OW-1:0]   res_slice;
  logic signed [EXT_W-1:0] res_slice_ext;
  logic [IDX_W-1:0]       res_id_ext;

  logic                   out_valid_r;
  logic [dms_pkg::OUT_DATA_W-1:0] out_data_r, out_data_nxt;
  logic [dms_pkg::OUT_USER_W-1:0] out_user_r, out_user_nxt;

  // Handshake: the summary register drains into the output register.
  assign out_free  = !out_valid_r || out_tready;
  assign fin_move  = fin_valid_r && out_free;
  assign in_tready = !fin_valid_r || fin_move;
  assign in_go     = in_tvalid && in_tready;

  // Entry accumulator.
  dms_acc #(
    .TIME_WIDTH (TIME_WIDTH),
    .ID_WIDTH   (ID_WIDTH)
  ) u_acc (
    .clk           (clk),
    .rst_n         (rst_n),
    .ent_go        (in_go),
    .ent_kind      (in_tuser),
    .ent_id        (in_tdata[ID_WIDTH-1:0]),
    .ent_rel       (in_tdata[ID_WIDTH +: TIME_WIDTH]),
    .ent_abs       (in_tdata[ID_WIDTH + TIME_WIDTH +: TIME_WIDTH]),
    .ent_rem       (in_tdata[ID_WIDTH + 2 * TIME_WIDTH +: TIME_WIDTH]),
    .ent_rel_at    (in_tdata[ID_WIDTH + 3 * TIME_WIDTH +: TIME_WIDTH]),
    .ent_now       (in_tdata[ID_WIDTH + 4 * TIME_WIDTH +: TIME_WIDTH]),
    .ent_last      (in_tlast),
    .sum_flags     (sum_flags),
    .sum_miss_id   (sum_miss_id),
    .sum_best_id   (sum_best_id),
    .sum_best_rem  (sum_best_rem),
    .sum_best_stop (sum_best_stop),
    .sum_rmin      (sum_rmin)
  );

  // Call summary register, loaded on the last request of a call.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fin_valid_r <= 1'b0;
    end else if (in_go && in_tlast) begin
      fin_valid_r <= 1'b1;
    end else if (fin_move) begin
      fin_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_go && in_tlast) begin
      fin_flags_r     <= sum_flags;
      fin_miss_id_r   <= sum_miss_id;
      fin_best_id_r   <= sum_best_id;
      fin_best_rem_r  <= sum_best_rem;
      fin_best_stop_r <= sum_best_stop;
      fin_rmin_r      <= sum_rmin;
    end
  end

  // Selection and slice from the call summary.
  always_comb begin
    res_stop = (fin_flags_r.rmin_found && (fin_rmin_r < fin_best_stop_r)) ?
               fin_rmin_r : fin_best_stop_r;
    if (fin_flags_r.miss_found) begin
      res_valid  = 1'b1;
      res_missed = 1'b1;
      res_id     = fin_miss_id_r;
      res_slice  = '0;
    end else if (fin_flags_r.best_found) begin
      res_valid  = 1'b1;
      res_missed = 1'b0;
      res_id     = fin_best_id_r;
      res_slice  = ($signed({1'b0, fin_best_rem_r}) < res_stop) ?
                   $signed({1'b0, fin_best_rem_r}) : res_stop;
    end else begin
      res_valid  = 1'b0;
      res_missed = 1'b0;
      res_id     = '0;
      res_slice  = fin_flags_r.rmin_found ? fin_rmin_r : OW'(1);
    end
    res_slice_ext = EXT_W'(res_slice);
    res_id_ext    = IDX_W'(res_id);
    out_data_nxt  = {res_slice_ext[dms_pkg::SLICE_W-1:0],
                     res_id_ext[dms_pkg::OUT_ID_W-1:0]};
    out_user_nxt  = '0;
    out_user_nxt[dms_pkg::USR_VALID]  = res_valid;
    out_user_nxt[dms_pkg::USR_MISSED] = res_missed;
    out_user_nxt[dms_pkg::USR_ORDER]  = fin_flags_r.order_err;
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= fin_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_move) begin
      out_data_r <= out_data_nxt;
      out_user_r <= out_user_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule

/* design/dms_checker.sv */
// ----------------------------------------------------------------------------
// dms_checker
// Port-level checks on the selector's result channel, bound to the top level.
// ----------------------------------------------------------------------------
module dms_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           out_tvalid,
  input logic                           out_tready,
  input logic [dms_pkg::OUT_DATA_W-1:0] out_tdata,
  input logic [dms_pkg::OUT_USER_W-1:0] out_tuser
);

  // A stalled result stays put.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // No result straight out of reset.
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // An idle result carries no thread and no miss.
  a_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[dms_pkg::USR_VALID] |->
      (out_tdata[dms_pkg::OUT_ID_W-1:0] == '0) && !out_tuser[dms_pkg::USR_MISSED])
    else $error("idle result carries a thread");

  // A missed deadline gets a zero slice on a chosen thread.
  a_miss: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[dms_pkg::USR_MISSED] |->
      out_tuser[dms_pkg::USR_VALID] &&
      (out_tdata[dms_pkg::OUT_DATA_W-1:dms_pkg::OUT_ID_W] == '0))
    else $error("missed deadline with nonzero slice");

endmodule

bind deadline_monotonic_selector_top dms_checker u_dms_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

/* sim/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the deadline-monotonic selector.
// ----------------------------------------------------------------------------
// Scheduling calls are streamed into the block as run and release entries.
// A predictor inside the bench tracks the call in progress and works out the
// chosen thread and its slice on every accepted last entry. Results from the
// block are checked in order against those predictions. A short directed
// table covers the corner cases, then random calls run under several mixes of
// sender idling and receiver stalling, including one long receiver hold-off.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TW = 31;
  localparam int IW = 16;
  localparam int IN_W = ((IW + 5 * TW + 7) / 8) * 8;
  localparam logic [TW-1:0] MAXT = 31'h7FFF_FFFF;
  localparam int CYCLE_LIMIT = 400_000;
  localparam int HOLD_CYCLES = 64;
  localparam int PHASE_ITEMS = 262;

  // One queue entry as it is offered to the block.
  typedef struct packed {
    logic          kind;
    logic [IW-1:0] tid;
    logic [TW-1:0] rel;
    logic [TW-1:0] absd;
    logic [TW-1:0] rem;
    logic [TW-1:0] rel_at;
    logic [TW-1:0] now;
    logic          last;
  } sched_req_t;

  // One scheduling decision.
  typedef struct packed {
    logic          valid;
    logic [15:0]   tid;
    logic [31:0]   slice;
    logic          missed;
    logic          order_err;
  } pick_t;

  // Directed row: a request and, where it is obvious, its typed-in decision.
  typedef struct packed {
    sched_req_t req;
    logic       fixed;
    pick_t      pick;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  logic [IN_W-1:0] in_tdata;
  logic in_tuser;
  logic in_tlast;
  logic out_tvalid;
  logic out_tready;
  logic [dms_pkg::OUT_DATA_W-1:0] out_tdata;
  logic [dms_pkg::OUT_USER_W-1:0] out_tuser;

  // Predictor state for the call in progress.
  logic          cur_open;
  logic [TW-1:0] cur_now;
  logic          cur_rel_phase;
  logic          cur_order_err;
  logic          cur_miss_seen;
  logic [IW-1:0] cur_miss_tid;
  logic          cur_top_seen;
  logic [IW-1:0] cur_top_tid;
  logic [TW-1:0] cur_top_rel;
  logic [TW-1:0] cur_top_abs;
  logic [TW-1:0] cur_top_rem;
  logic          cur_rel_seen;
  longint        cur_rel_off;

  pick_t    expected_picks[$];
  dir_row_t directed_rows[$];
  int       items_sent = 0;
  int       results_seen = 0;
  int       mismatches = 0;
  int       cycle_count = 0;
  int       send_idle_pct = 0;
  int       stall_pct = 0;
  bit       hold_pending = 1'b0;
  pick_t    got_pick;
  pick_t    want_pick;

  deadline_monotonic_selector_top #(
    .TIME_WIDTH(TW),
    .ID_WIDTH  (IW)
  ) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  always #10 clk = ~clk;

  // Clear everything that belongs to one call.
  function automatic void forget_call();
    cur_open = 1'b0;
    cur_now = '0;
    cur_rel_phase = 1'b0;
    cur_order_err = 1'b0;
    cur_miss_seen = 1'b0;
    cur_miss_tid = '0;
    cur_top_seen = 1'b0;
    cur_top_tid = '0;
    cur_top_rel = '0;
    cur_top_abs = '0;
    cur_top_rem = '0;
    cur_rel_seen = 1'b0;
    cur_rel_off = 0;
  endfunction

  // Deadline-monotonic order: smaller relative deadline, then smaller ID.
  function automatic bit ahead_of_top(input logic [TW-1:0] rel, input logic [IW-1:0] tid);
    if (rel != cur_top_rel) return rel < cur_top_rel;
    return tid < cur_top_tid;
  endfunction

  // Fold one accepted entry into the call; returns 1 with a decision on last.
  function automatic bit dm_step(input sched_req_t r, output pick_t p);
    longint off;
    longint stop;
    longint slice;
    p = '0;
    if (!cur_open) begin
      cur_open = 1'b1;
      cur_now = r.now;
    end
    if (r.kind == dms_pkg::KIND_RUN) begin
      // A run entry after the release entries is flagged and otherwise dropped.
      if (cur_rel_phase) begin
        cur_order_err = 1'b1;
      end else begin
        if (r.absd <= cur_now && (!cur_miss_seen || r.tid < cur_miss_tid)) begin
          cur_miss_seen = 1'b1;
          cur_miss_tid = r.tid;
        end
        if (!cur_top_seen || ahead_of_top(r.rel, r.tid)) begin
          cur_top_seen = 1'b1;
          cur_top_tid = r.tid;
          cur_top_rel = r.rel;
          cur_top_abs = r.absd;
          cur_top_rem = r.rem;
        end
      end
    end else begin
      // Only releases that would preempt the current pick bound its slice.
      cur_rel_phase = 1'b1;
      if (!cur_top_seen || ahead_of_top(r.rel, r.tid)) begin
        off = longint'(r.rel_at) - longint'(cur_now);
        if (!cur_rel_seen || off < cur_rel_off) begin
          cur_rel_seen = 1'b1;
          cur_rel_off = off;
        end
      end
    end
    if (!r.last) return 1'b0;

    if (cur_miss_seen) begin
      p.valid = 1'b1;
      p.tid = cur_miss_tid;
      p.missed = 1'b1;
      slice = 0;
    end else if (cur_top_seen) begin
      stop = longint'(cur_top_abs) - longint'(cur_now);
      if (cur_rel_seen && cur_rel_off < stop) stop = cur_rel_off;
      p.valid = 1'b1;
      p.tid = cur_top_tid;
      slice = (longint'(cur_top_rem) < stop) ? longint'(cur_top_rem) : stop;
    end else begin
      slice = cur_rel_seen ? cur_rel_off : 1;
    end
    p.slice = slice[31:0];
    p.order_err = cur_order_err;
    forget_call();
    return 1'b1;
  endfunction

  // Offer one request, wait for the handshake and record what it should give.
  task automatic send_request(input sched_req_t r, input logic fixed, input pick_t fixed_pick);
    pick_t p;
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {{(IN_W - IW - 5 * TW){1'b0}}, r.now, r.rel_at, r.rem, r.absd, r.rel, r.tid};
    in_tuser <= r.kind;
    in_tlast <= r.last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    items_sent++;
    if (dm_step(r, p)) expected_picks.push_back(fixed ? fixed_pick : p);
  endtask

  task automatic add_req(input logic kind, input logic [IW-1:0] tid, input logic [TW-1:0] rel,
                         input logic [TW-1:0] absd, input logic [TW-1:0] rem,
                         input logic [TW-1:0] rel_at, input logic [TW-1:0] now,
                         input logic last);
    dir_row_t row;
    row = '0;
    row.req = '{kind, tid, rel, absd, rem, rel_at, now, last};
    directed_rows.push_back(row);
  endtask

  // Attach a typed-in decision to the row just added.
  task automatic add_fixed(input logic valid, input logic [15:0] tid, input logic [31:0] slice,
                           input logic missed, input logic order_err);
    dir_row_t row;
    row = directed_rows.pop_back();
    row.fixed = 1'b1;
    row.pick = '{valid, tid, slice, missed, order_err};
    directed_rows.push_back(row);
  endtask

  function automatic logic [TW-1:0] pick_now();
    case ($urandom_range(9))
      0: return '0;
      1: return MAXT;
      2, 3, 4: return TW'($urandom_range(0, 1000));
      default: return TW'($urandom());
    endcase
  endfunction

  // A time that often lands close to the call's current time.
  function automatic logic [TW-1:0] time_near(input logic [TW-1:0] now);
    longint t;
    case ($urandom_range(9))
      0, 1: return TW'($urandom());
      2: return '0;
      3: return MAXT;
      4: return now;
      default: begin
        t = longint'(now) + longint'($urandom_range(0, 80)) - 40;
        if (t < 0) t = 0;
        if (t > longint'(MAXT)) t = longint'(MAXT);
        return t[TW-1:0];
      end
    endcase
  endfunction

  // Random entry content; small ID and deadline ranges make ties common.
  function automatic sched_req_t random_entry(input logic [TW-1:0] now, input logic kind);
    sched_req_t r;
    r.kind = kind;
    r.tid = ($urandom_range(9) < 8) ? IW'($urandom_range(0, 15)) : IW'($urandom());
    r.rel = ($urandom_range(9) < 8) ? TW'($urandom_range(0, 7)) : TW'($urandom());
    r.absd = time_near(now);
    r.rem = ($urandom_range(9) < 7) ? TW'($urandom_range(0, 200)) : TW'($urandom());
    r.rel_at = time_near(now);
    r.now = TW'($urandom());
    r.last = 1'b0;
    return r;
  endfunction

  // One call: run entries, then release entries, sometimes out of order.
  task automatic random_call();
    sched_req_t q[$];
    sched_req_t r;
    int n_run;
    int n_rel;
    logic [TW-1:0] now;
    n_run = $urandom_range(0, 5);
    n_rel = $urandom_range(0, 3);
    if (n_run + n_rel == 0) n_run = 1;
    now = pick_now();
    for (int i = 0; i < n_run + n_rel; i++) begin
      r = random_entry(now, (i < n_run) ? dms_pkg::KIND_RUN : dms_pkg::KIND_RELEASE);
      // Occasional noise: an entry of the wrong kind anywhere in the call.
      if ($urandom_range(19) == 0) r.kind = ~r.kind;
      q.push_back(r);
    end
    // About one call in ten that has release entries gets a late run entry among them.
    if (n_rel > 0 && $urandom_range(9) == 0) begin
      r = random_entry(now, dms_pkg::KIND_RUN);
      q.insert($urandom_range(n_run + 1, q.size()), r);
    end
    q[0].now = now;
    q[q.size() - 1].last = 1'b1;
    foreach (q[i]) send_request(q[i], 1'b0, '0);
  endtask

  // Receiver: random stalls, plus a long hold-off when requested.
  initial begin
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_pending) begin
        hold_pending = 1'b0;
        for (int n = 0; n < HOLD_CYCLES; n++) begin
          out_tready <= 1'b0;
          @(posedge clk);
        end
      end
      out_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Compare every accepted result with the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      got_pick.valid = out_tuser[dms_pkg::USR_VALID];
      got_pick.tid = out_tdata[dms_pkg::OUT_ID_W-1:0];
      got_pick.slice = out_tdata[dms_pkg::OUT_ID_W +: dms_pkg::SLICE_W];
      got_pick.missed = out_tuser[dms_pkg::USR_MISSED];
      got_pick.order_err = out_tuser[dms_pkg::USR_ORDER];
      if (expected_picks.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result %0d arrived with nothing expected: id=%0d slice=%0d",
                   results_seen, got_pick.tid, $signed(got_pick.slice));
      end else begin
        want_pick = expected_picks.pop_front();
        if (got_pick.valid !== want_pick.valid || got_pick.tid !== want_pick.tid ||
            got_pick.slice !== want_pick.slice || got_pick.missed !== want_pick.missed ||
            got_pick.order_err !== want_pick.order_err) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("result %0d mismatch: exp valid=%0b id=%0d slice=%0d missed=%0b order=%0b",
                     results_seen, want_pick.valid, want_pick.tid, $signed(want_pick.slice),
                     want_pick.missed, want_pick.order_err);
            $display("                     got valid=%0b id=%0d slice=%0d missed=%0b order=%0b",
                     got_pick.valid, got_pick.tid, $signed(got_pick.slice),
                     got_pick.missed, got_pick.order_err);
          end
        end
      end
    end
  end

  // Guard against a hung handshake.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    sched_req_t r;
    int target;
    int idle_mix[4];
    int stall_mix[4];
    idle_mix = '{0, 78, 0, 28};
    stall_mix = '{0, 0, 78, 28};
    in_tvalid <= 1'b0;
    in_tdata <= '0;
    in_tuser <= 1'b0;
    in_tlast <= 1'b0;
    rst_n <= 1'b0;
    forget_call();

    // Single-item call with a plain pick: slice is the remaining work.
    add_req(dms_pkg::KIND_RUN, 16'd5, 31'd100, 31'd1000, 31'd30, 31'd0, 31'd500, 1'b1);
    add_fixed(1'b1, 16'd5, 32'd30, 1'b0, 1'b0);
    // Release-only call: slice is the offset to the release.
    add_req(dms_pkg::KIND_RELEASE, 16'd7, 31'd10, 31'd0, 31'd0, 31'd900, 31'd400, 1'b1);
    add_fixed(1'b0, 16'd0, 32'd500, 1'b0, 1'b0);
    // Release already in the past: the negative offset comes out as is.
    add_req(dms_pkg::KIND_RELEASE, 16'd0, 31'd0, 31'd0, 31'd0, 31'd100, 31'd300, 1'b1);
    add_fixed(1'b0, 16'd0, -32'sd200, 1'b0, 1'b0);
    // Largest possible offset.
    add_req(dms_pkg::KIND_RELEASE, 16'hFFFF, MAXT, MAXT, MAXT, MAXT, 31'd0, 1'b1);
    add_fixed(1'b0, 16'd0, 32'h7FFF_FFFF, 1'b0, 1'b0);
    // Missed deadlines: smallest missing ID wins, time comes from the first entry.
    add_req(dms_pkg::KIND_RUN, 16'd9, 31'd5, 31'd50, 31'd20, 31'd0, 31'd50, 1'b0);
    add_req(dms_pkg::KIND_RUN, 16'd3, 31'd7, 31'd10, 31'd20, 31'd0, 31'd0, 1'b0);
    add_req(dms_pkg::KIND_RUN, 16'd1, 31'd1, 31'd1000, 31'd20, 31'd0, 31'd0, 1'b1);
    add_fixed(1'b1, 16'd3, 32'd0, 1'b1, 1'b0);
    // Late run entry after a release: flagged and ignored.
    add_req(dms_pkg::KIND_RUN, 16'd4, 31'd20, 31'd1000, 31'd100, 31'd0, 31'd0, 1'b0);
    add_req(dms_pkg::KIND_RELEASE, 16'd2, 31'd5, 31'd0, 31'd0, 31'd40, 31'd0, 1'b0);
    add_req(dms_pkg::KIND_RUN, 16'd1, 31'd1, 31'd0, 31'd5, 31'd0, 31'd0, 1'b1);
    add_fixed(1'b1, 16'd4, 32'd40, 1'b0, 1'b1);
    // All fields at their top value, time zero.
    add_req(dms_pkg::KIND_RUN, 16'hFFFF, MAXT, MAXT, MAXT, MAXT, 31'd0, 1'b1);
    add_fixed(1'b1, 16'hFFFF, 32'h7FFF_FFFF, 1'b0, 1'b0);
    // Deadline equal to the largest current time counts as missed.
    add_req(dms_pkg::KIND_RUN, 16'd0, 31'd0, MAXT, MAXT, 31'd0, MAXT, 1'b1);
    add_fixed(1'b1, 16'd0, 32'd0, 1'b1, 1'b0);
    // Ties on relative deadline, and releases that do and do not preempt.
    add_req(dms_pkg::KIND_RUN, 16'd10, 31'd50, 31'd500, 31'd80, 31'd0, 31'd100, 1'b0);
    add_req(dms_pkg::KIND_RUN, 16'd8, 31'd50, 31'd300, 31'd500, 31'd0, 31'd0, 1'b0);
    add_req(dms_pkg::KIND_RUN, 16'd12, 31'd40, 31'd900, 31'd900, 31'd0, 31'd0, 1'b0);
    add_req(dms_pkg::KIND_RELEASE, 16'd1, 31'd60, 31'd0, 31'd0, 31'd150, 31'd0, 1'b0);
    add_req(dms_pkg::KIND_RELEASE, 16'd13, 31'd40, 31'd0, 31'd0, 31'd160, 31'd0, 1'b0);
    add_req(dms_pkg::KIND_RELEASE, 16'd11, 31'd40, 31'd0, 31'd0, 31'd400, 31'd0, 1'b1);
    // Several releases with no run entry: the nearest one sets the slice.
    add_req(dms_pkg::KIND_RELEASE, 16'd3, 31'd9, 31'd0, 31'd0, 31'd1000, 31'd200, 1'b0);
    add_req(dms_pkg::KIND_RELEASE, 16'd4, 31'd2, 31'd0, 31'd0, 31'd700, 31'd0, 1'b0);
    add_req(dms_pkg::KIND_RELEASE, 16'd5, 31'd0, 31'd0, 31'd0, 31'd5000, 31'd0, 1'b1);
    // Most negative offset the fields allow.
    add_req(dms_pkg::KIND_RELEASE, 16'd6, 31'd0, 31'd0, 31'd0, 31'd0, MAXT, 1'b1);
    add_fixed(1'b0, 16'd0, 32'h8000_0001, 1'b0, 1'b0);

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i])
      send_request(directed_rows[i].req, directed_rows[i].fixed, directed_rows[i].pick);

    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = idle_mix[ph];
      stall_pct = stall_mix[ph];
      // Back-to-back single-entry calls against a stalled sink fill the block.
      if (ph == 0) begin
        hold_pending = 1'b1;
        for (int k = 0; k < 12; k++) begin
          r = random_entry(pick_now(), 1'($urandom()));
          r.last = 1'b1;
          send_request(r, 1'b0, '0);
        end
      end
      target = items_sent + PHASE_ITEMS;
      while (items_sent < target) random_call();
    end
    in_tvalid <= 1'b0;

    while (expected_picks.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

/* sim.f */
design/dms_pkg.sv
design/dms_acc.sv
design/deadline_monotonic_selector_top.sv
design/dms_checker.sv
sim/tb_top.sv
